FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// cause at one edge implies effect at the next edge
`define ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

FILE: design/olme_pkg.sv
// ----------------------------------------------------------------------------
// olme_pkg
// shared types and constants of the ordered list move engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olme_pkg;

    localparam int OP_W   = 3;
    localparam int ITEM_W = 7;
    localparam int LEN_W  = 7;

    localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_REBUILD    = 3'd0,
        OP_MOVE_FRONT = 3'd1,
        OP_MOVE_BACK  = 3'd2,
        OP_MOVE_AFTER = 3'd3,
        OP_DUMP       = 3'd4
    } op_e;

    // one request
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ITEM_W-1:0] item;
        logic [ITEM_W-1:0] anchor;
    } req_t;

    // one dump result
    typedef struct packed {
        logic [ITEM_W-1:0] item_out;
        logic              last;
    } rsp_t;

endpackage

FILE: design/olme_link_mem.sv
// ----------------------------------------------------------------------------
// olme_link_mem
// link table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olme_link_mem #(
    parameter int DEPTH = 66,
    parameter int W     = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [W-1:0]             wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [W-1:0]             rd_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/ordered_list_move_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_move_engine_top
// ordering of items 1..n kept as an index-linked doubly linked list
// ----------------------------------------------------------------------------
// The ordering lives in two link memories (next and prev, MAX_ITEMS+2 slots,
// slot 0 the head sentinel and slot n+1 the tail sentinel), each with one
// write port and one registered read port, driven by a small sequencer that
// does one memory step per cycle unless a dump item waits for the output
// register. One request is taken at a time and req_stall is high while it is
// worked on. Ignored moves and unknown operations leave the sequencer idle.
// Move to front or after anchor steps through reading the item's links,
// unlinking it, reading the anchor's next link and two link writes; move to
// back adds one read of the tail sentinel after the unlink. Rebuild sweeps
// all slots, writing one slot of both memories per step. Dump reads the next
// link and then loads the output register for each item, and waits while
// rsp_stall holds. After reset the same rebuild sweep runs once before the
// first request is taken; a write of list_length also starts it. The dump
// result sits in an output register, so a new request can be accepted while
// the final dump item still waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_move_engine_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  olme_pkg::req_t               req,
    // dump result channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output olme_pkg::rsp_t               rsp,
    // list_length register
    input  logic                         cfg_wen,
    input  logic [olme_pkg::LEN_W-1:0]   cfg_wdata
);

    localparam int SLOTS = MAX_ITEMS + 2;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int LW    = olme_pkg::LEN_W;
    localparam int IW    = olme_pkg::ITEM_W;

    localparam logic [LW-1:0]    MAX_LEN   = LW'(MAX_ITEMS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    // sequencer states
    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_REBUILD   = 10'b00_0000_0010,
        ST_RD_X      = 10'b00_0000_0100,
        ST_UNLINK    = 10'b00_0000_1000,
        ST_RD_TAIL   = 10'b00_0001_0000,
        ST_RD_ANCHOR = 10'b00_0010_0000,
        ST_LINK_A    = 10'b00_0100_0000,
        ST_LINK_B    = 10'b00_1000_0000,
        ST_DUMP_RD   = 10'b01_0000_0000,
        ST_DUMP_LD   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [LW-1:0]      list_length_reg;
    olme_pkg::op_e      op_reg, op_next;
    logic [IDX_W-1:0]   x_reg, x_next;        // item being moved
    logic [IDX_W-1:0]   anc_reg, anc_next;    // slot the item goes after
    logic [IDX_W-1:0]   cur_reg, cur_next;    // dump walk position
    logic [LW-1:0]      cnt_reg, cnt_next;    // dump items given so far
    logic [IDX_W-1:0]   idx_reg, idx_next;    // rebuild sweep slot

    olme_pkg::rsp_t     rsp_reg, rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_load;

    // memory ports
    logic               nx_we, pv_we, nx_re, pv_re;
    logic [IDX_W-1:0]   nx_waddr, pv_waddr, nx_raddr, pv_raddr;
    logic [IDX_W-1:0]   nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic [LW-1:0]      eff_len;
    logic [IDX_W-1:0]   tail_slot;
    logic               x_ok, y_ok;
    logic               dump_last;
    logic [LW-1:0]      idx_ext;
    logic               idx_in_list;
    logic [IDX_W-1:0]   reb_next_w, reb_prev_w;
    logic [IDX_W-1:0]   anchor_sel;

    // effective length, saturated into 1..MAX_ITEMS
    always_comb
    begin
        if (list_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (list_length_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = list_length_reg;
        end
    end

    assign tail_slot = IDX_W'(eff_len + LW'(1));

    // range checks on the incoming request
    assign x_ok = (req.item != '0) && (req.item <= eff_len);
    assign y_ok = (req.anchor != '0) && (req.anchor <= eff_len);

    assign dump_last = (cnt_reg == eff_len - LW'(1));

    // rebuild values for the slot under the sweep
    assign idx_ext     = LW'(idx_reg);
    assign idx_in_list = (idx_ext != '0) && (idx_ext <= eff_len);

    always_comb
    begin
        if (idx_reg == '0)
        begin
            reb_next_w = IDX_W'(1);
        end
        else if (idx_in_list)
        begin
            reb_next_w = idx_reg + IDX_W'(1);
        end
        else
        begin
            reb_next_w = '0;
        end

        if (idx_in_list)
        begin
            reb_prev_w = idx_reg - IDX_W'(1);
        end
        else if (idx_reg == tail_slot)
        begin
            reb_prev_w = IDX_W'(eff_len);
        end
        else
        begin
            reb_prev_w = '0;
        end
    end

    // move to back goes after the tail's predecessor, read just before
    assign anchor_sel = (op_reg == olme_pkg::OP_MOVE_BACK) ? pv_rdata : anc_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        anc_next   = anc_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        nx_we      = 1'b0;
        nx_waddr   = '0;
        nx_wdata   = '0;
        pv_we      = 1'b0;
        pv_waddr   = '0;
        pv_wdata   = '0;
        nx_re      = 1'b0;
        nx_raddr   = '0;
        pv_re      = 1'b0;
        pv_raddr   = '0;
        rsp_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = olme_pkg::op_e'(req.operation);
                    x_next   = req.item[IDX_W-1:0];
                    anc_next = req.anchor[IDX_W-1:0];
                    case (olme_pkg::op_e'(req.operation))
                        olme_pkg::OP_REBUILD:
                        begin
                            idx_next   = '0;
                            state_next = ST_REBUILD;
                        end
                        olme_pkg::OP_MOVE_FRONT:
                        begin
                            // head sentinel is the anchor
                            anc_next = '0;
                            if (x_ok)
                            begin
                                state_next = ST_RD_X;
                            end
                        end
                        olme_pkg::OP_MOVE_BACK:
                        begin
                            if (x_ok)
                            begin
                                state_next = ST_RD_X;
                            end
                        end
                        olme_pkg::OP_MOVE_AFTER:
                        begin
                            if (x_ok && y_ok && (req.item != req.anchor))
                            begin
                                state_next = ST_RD_X;
                            end
                        end
                        olme_pkg::OP_DUMP:
                        begin
                            cur_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REBUILD:
            begin
                nx_we    = 1'b1;
                nx_waddr = idx_reg;
                nx_wdata = reb_next_w;
                pv_we    = 1'b1;
                pv_waddr = idx_reg;
                pv_wdata = reb_prev_w;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_X:
            begin
                nx_re      = 1'b1;
                nx_raddr   = x_reg;
                pv_re      = 1'b1;
                pv_raddr   = x_reg;
                state_next = ST_UNLINK;
            end
            ST_UNLINK:
            begin
                // next[prev x] = next x, prev[next x] = prev x
                nx_we    = 1'b1;
                nx_waddr = pv_rdata;
                nx_wdata = nx_rdata;
                pv_we    = 1'b1;
                pv_waddr = nx_rdata;
                pv_wdata = pv_rdata;
                if (op_reg == olme_pkg::OP_MOVE_BACK)
                begin
                    state_next = ST_RD_TAIL;
                end
                else
                begin
                    state_next = ST_RD_ANCHOR;
                end
            end
            ST_RD_TAIL:
            begin
                pv_re      = 1'b1;
                pv_raddr   = tail_slot;
                state_next = ST_RD_ANCHOR;
            end
            ST_RD_ANCHOR:
            begin
                anc_next   = anchor_sel;
                nx_re      = 1'b1;
                nx_raddr   = anchor_sel;
                state_next = ST_LINK_A;
            end
            ST_LINK_A:
            begin
                // next[x] = follower, prev[follower] = x
                nx_we      = 1'b1;
                nx_waddr   = x_reg;
                nx_wdata   = nx_rdata;
                pv_we      = 1'b1;
                pv_waddr   = nx_rdata;
                pv_wdata   = x_reg;
                state_next = ST_LINK_B;
            end
            ST_LINK_B:
            begin
                // next[anchor] = x, prev[x] = anchor
                nx_we      = 1'b1;
                nx_waddr   = anc_reg;
                nx_wdata   = x_reg;
                pv_we      = 1'b1;
                pv_waddr   = x_reg;
                pv_wdata   = anc_reg;
                state_next = ST_IDLE;
            end
            ST_DUMP_RD:
            begin
                nx_re      = 1'b1;
                nx_raddr   = cur_reg;
                state_next = ST_DUMP_LD;
            end
            ST_DUMP_LD:
            begin
                // wait for a free output register
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load = 1'b1;
                    cur_next = nx_rdata;
                    cnt_next = cnt_reg + LW'(1);
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write restarts the order
        if (cfg_wen)
        begin
            idx_next   = '0;
            state_next = ST_REBUILD;
        end
    end

    always_comb
    begin
        rsp_next.item_out = IW'(nx_rdata);
        rsp_next.last     = dump_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_REBUILD;
            idx_reg         <= '0;
            cur_reg         <= '0;
            cnt_reg         <= '0;
            list_length_reg <= olme_pkg::LIST_LENGTH_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen)
            begin
                list_length_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        anc_reg <= anc_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // next links
    olme_link_mem #(
        .DEPTH (SLOTS),
        .W     (IDX_W)
    ) u_next_mem (
        .clk     (clk),
        .wr_en   (nx_we),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata),
        .rd_en   (nx_re),
        .rd_addr (nx_raddr),
        .rd_data (nx_rdata)
    );

    // prev links
    olme_link_mem #(
        .DEPTH (SLOTS),
        .W     (IDX_W)
    ) u_prev_mem (
        .clk     (clk),
        .wr_en   (pv_we),
        .wr_addr (pv_waddr),
        .wr_data (pv_wdata),
        .rd_en   (pv_re),
        .rd_addr (pv_raddr),
        .rd_data (pv_rdata)
    );

    // requests wait while busy or while the register is written
    assign req_stall = (state_reg != ST_IDLE) || cfg_wen;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/olme_checker.sv
// ----------------------------------------------------------------------------
// olme_checker
// port-level checks of the ordered list move engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module olme_checker #(
    parameter int MAX_ITEMS = 64
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input olme_pkg::req_t             req,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input olme_pkg::rsp_t             rsp,
    input logic                       cfg_wen,
    input logic [olme_pkg::LEN_W-1:0] cfg_wdata
);

    localparam int IW = olme_pkg::ITEM_W;
    localparam logic [IW-1:0] MAX_ITEM = IW'(MAX_ITEMS);

    logic dump_taken;
    logic cfg_seen;

    assign dump_taken = req_valid && !req_stall
                        && (req.operation == olme_pkg::OP_DUMP);
    assign cfg_seen   = cfg_wen && (cfg_wdata == cfg_wdata);

    // a stalled result holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

    // dumped items are real items
    `ASSERT_CLK(a_rsp_range, clk, rst_n, !rsp_valid || ((rsp.item_out != '0) && (rsp.item_out <= MAX_ITEM)), "dump item out of range")

    // no request taken during a register write
    `ASSERT_CLK(a_cfg_block, clk, rst_n, !cfg_seen || req_stall, "request accepted with register write")

    // a dump keeps the engine busy
    `ASSERT_NEXT(a_dump_busy, clk, rst_n, dump_taken, req_stall, "engine free right after dump request")

endmodule

bind ordered_list_move_engine_top olme_checker #(
    .MAX_ITEMS (MAX_ITEMS)
) u_olme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
);

FILE: test/ordered_list_move_engine_top_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_move_engine_top_tb
// self-checking bench for the ordered list move engine
// ----------------------------------------------------------------------------
// Drives requests (rebuild, moves, dumps, unknown codes) through the
// valid/stall request channel. A local copy of the linked ordering predicts
// the items that every dump returns. A monitor compares each accepted result
// with the oldest prediction. The list length is rewritten between phases,
// with its extremes included. Both channels idle at random. One phase holds
// the result side off for a long time so that the engine backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_move_engine_top_tb;

    localparam int OP_W   = olme_pkg::OP_W;
    localparam int ITEM_W = olme_pkg::ITEM_W;
    localparam int LEN_W  = olme_pkg::LEN_W;

    localparam int MAX_ITEMS     = 64;
    localparam int SLOT_COUNT    = MAX_ITEMS + 2;
    // wait that outlasts the engine's longest busy time with no result pending (rebuild sweep)
    localparam int SETTLE_CYCLES = 2 * MAX_ITEMS + 8;
    localparam int IDLE_PCT      = 29;
    localparam int LONG_HOLD     = 300;

    // operation codes the engine does not know
    localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic           req_valid = 1'b0;
    logic           req_stall;
    olme_pkg::req_t req       = '0;

    // result channel
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    olme_pkg::rsp_t rsp;

    // list_length register port
    logic             cfg_wen   = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    // predicted ordering: slot 0 is the head sentinel, slot n+1 the tail
    logic [ITEM_W-1:0] order_next [SLOT_COUNT];
    logic [ITEM_W-1:0] order_prev [SLOT_COUNT];
    logic [LEN_W-1:0]  length_reg;

    // dump items still owed by the engine, oldest first
    olme_pkg::rsp_t dump_expect [$];
    olme_pkg::rsp_t dump_want;

    // idling control and long hold-off of the result side
    bit calm_req      = 1'b0;
    bit calm_rsp      = 1'b0;
    int hold_request  = 0;
    int hold_left     = 0;

    // bookkeeping
    int mismatches    = 0;
    int requests_sent = 0;
    int dumps_sent    = 0;
    int results_seen  = 0;
    int length_writes = 0;

    ordered_list_move_engine_top #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor of the linked ordering
    // ------------------------------------------------------------------------

    // length register saturated into 1..MAX_ITEMS
    function automatic int active_len();
        int n;
        n = length_reg;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_ITEMS)
        begin
            n = MAX_ITEMS;
        end
        return n;
    endfunction

    // a link that points past the slot range falls back to the head
    function automatic int to_slot(input int v);
        return (v < SLOT_COUNT) ? v : 0;
    endfunction

    function automatic void rebuild_order();
        int n;
        n = active_len();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            order_next[i] = '0;
            order_prev[i] = '0;
        end
        for (int i = 1; i <= n; i++)
        begin
            order_prev[i] = ITEM_W'(i - 1);
            order_next[i] = ITEM_W'(i + 1);
        end
        order_next[0]     = ITEM_W'(1);
        order_prev[n + 1] = ITEM_W'(n);
    endfunction

    function automatic void unlink_slot(input int x);
        int p;
        int q;
        p = to_slot(order_prev[x]);
        q = to_slot(order_next[x]);
        order_next[p] = ITEM_W'(q);
        order_prev[q] = ITEM_W'(p);
    endfunction

    // put x between p and whatever follows p now
    function automatic void link_after(input int x, input int p);
        int q;
        q = to_slot(order_next[p]);
        order_next[x] = ITEM_W'(q);
        order_prev[x] = ITEM_W'(p);
        order_prev[q] = ITEM_W'(x);
        order_next[p] = ITEM_W'(x);
    endfunction

    // update the ordering for one accepted request, queue any dump items
    function automatic void apply_request(input olme_pkg::req_t r);
        int             n;
        int             x;
        int             y;
        int             cur;
        bit             x_ok;
        bit             y_ok;
        olme_pkg::rsp_t e;
        n    = active_len();
        x    = r.item;
        y    = r.anchor;
        x_ok = (x >= 1) && (x <= n);
        y_ok = (y >= 1) && (y <= n);
        case (r.operation)
            olme_pkg::OP_REBUILD:
            begin
                rebuild_order();
            end
            olme_pkg::OP_MOVE_FRONT:
            begin
                if (x_ok)
                begin
                    unlink_slot(x);
                    link_after(x, 0);
                end
            end
            olme_pkg::OP_MOVE_BACK:
            begin
                // the tail's predecessor is read after the item is unlinked
                if (x_ok)
                begin
                    unlink_slot(x);
                    link_after(x, to_slot(order_prev[n + 1]));
                end
            end
            olme_pkg::OP_MOVE_AFTER:
            begin
                if (x_ok && y_ok && (x != y))
                begin
                    unlink_slot(x);
                    link_after(x, y);
                end
            end
            olme_pkg::OP_DUMP:
            begin
                cur = to_slot(order_next[0]);
                for (int k = 0; k < n; k++)
                begin
                    e.item_out = ITEM_W'(cur);
                    e.last     = (k == n - 1);
                    dump_expect.push_back(e);
                    cur = to_slot(order_next[cur]);
                end
            end
            default:
            begin
                // unknown codes leave the ordering alone
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------------

    // long hold-offs are requested at a falling edge and counted down here
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (calm_rsp)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // values sampled at the edge are the ones the engine held before it
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (dump_expect.size() == 0)
            begin
                report_mismatch($sformatf("unexpected dump item %0d last %0b",
                                          rsp.item_out, rsp.last));
            end
            else
            begin
                dump_want = dump_expect.pop_front();
                if (rsp.item_out !== dump_want.item_out)
                begin
                    report_mismatch($sformatf("item_out %0d, expected %0d",
                                              rsp.item_out, dump_want.item_out));
                end
                if (rsp.last !== dump_want.last)
                begin
                    report_mismatch($sformatf("last %0b, expected %0b (item %0d)",
                                              rsp.last, dump_want.last,
                                              dump_want.item_out));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side helpers
    // ------------------------------------------------------------------------

    function automatic olme_pkg::req_t make_req(input logic [OP_W-1:0]   op,
                                                input logic [ITEM_W-1:0] item,
                                                input logic [ITEM_W-1:0] anchor);
        olme_pkg::req_t r;
        r.operation = op;
        r.item      = item;
        r.anchor    = anchor;
        return r;
    endfunction

    // mostly in-range moves and dumps, some stray items, codes and rebuilds
    function automatic olme_pkg::req_t rand_req();
        int                n;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ITEM_W-1:0] x;
        logic [ITEM_W-1:0] y;
        n    = active_len();
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            op = olme_pkg::OP_DUMP;
        end
        else if (pick < 42)
        begin
            op = olme_pkg::OP_MOVE_FRONT;
        end
        else if (pick < 62)
        begin
            op = olme_pkg::OP_MOVE_BACK;
        end
        else if (pick < 88)
        begin
            op = olme_pkg::OP_MOVE_AFTER;
        end
        else if (pick < 94)
        begin
            op = olme_pkg::OP_REBUILD;
        end
        else
        begin
            op = OP_W'($urandom_range(OP_UNKNOWN_LAST, OP_UNKNOWN_FIRST));
        end
        x = ($urandom_range(99) < 85) ? ITEM_W'($urandom_range(n, 1))
                                      : ITEM_W'($urandom());
        y = ($urandom_range(99) < 85) ? ITEM_W'($urandom_range(n, 1))
                                      : ITEM_W'($urandom());
        return make_req(op, x, y);
    endfunction

    // offer one request, hold it until taken, then predict its effect;
    // valid is left high so a following request can go out without a gap
    task automatic send_req(input olme_pkg::req_t r);
        while (!calm_req && ($urandom_range(99) < IDLE_PCT))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        apply_request(r);
        requests_sent++;
        if (r.operation == olme_pkg::OP_DUMP)
        begin
            dumps_sent++;
        end
    endtask

    // sender pauses until every predicted dump item has come back
    task automatic wait_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (dump_expect.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register writes only while the engine is idle
    task automatic write_length(input logic [LEN_W-1:0] value);
        wait_drain();
        // a trailing move or rebuild may still be running with nothing owed
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        length_reg = value;
        rebuild_order();
        length_writes++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // the ordering right after reset is 1..64
    task automatic test_reset_order();
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        wait_drain();
    endtask

    // one-item list, zero and oversized lengths, stray item past the end
    task automatic test_length_extremes();
        write_length(7'd1);
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        send_req(make_req(olme_pkg::OP_MOVE_FRONT, 7'd1, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_BACK, 7'd1, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd1, 7'd1));
        send_req(make_req(olme_pkg::OP_DUMP, 7'd127, 7'd127));
        // zero counts as one
        write_length(7'd0);
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        // all ones saturates to the full size
        write_length(7'd127);
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        // one past the full size, item 65 lies outside the list
        write_length(7'd65);
        send_req(make_req(olme_pkg::OP_MOVE_BACK, 7'd65, 7'd0));
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        wait_drain();
    endtask

    // each operation, ignored moves and unknown codes on the full list
    task automatic test_directed_moves();
        write_length(olme_pkg::LIST_LENGTH_RESET);
        send_req(make_req(olme_pkg::OP_MOVE_FRONT, 7'd64, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_BACK, 7'd1, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd32, 7'd64));
        // item equal to anchor does nothing
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd5, 7'd5));
        // anchor or item outside 1..n are ignored
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd5, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd5, 7'd127));
        send_req(make_req(olme_pkg::OP_MOVE_AFTER, 7'd127, 7'd3));
        send_req(make_req(olme_pkg::OP_MOVE_FRONT, 7'd0, 7'd0));
        send_req(make_req(olme_pkg::OP_MOVE_BACK, 7'd127, 7'd127));
        for (int op = OP_UNKNOWN_FIRST; op <= OP_UNKNOWN_LAST; op++)
        begin
            send_req(make_req(OP_W'(op), ITEM_W'($urandom_range(64, 1)),
                              ITEM_W'($urandom())));
        end
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        send_req(make_req(olme_pkg::OP_REBUILD, 7'd127, 7'd127));
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        wait_drain();
    endtask

    // result side held off for a long time while requests keep coming,
    // so the engine sits on a pending dump item and stalls its input
    task automatic test_backpressure();
        write_length(7'd12);
        @(negedge clk);
        hold_request = LONG_HOLD;
        @(posedge clk);
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        repeat (4)
        begin
            send_req(rand_req());
        end
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        repeat (4)
        begin
            send_req(rand_req());
        end
        wait_drain();
    endtask

    // sender waits for the ordering to be fully drained mid-sequence
    task automatic test_drain_pause();
        repeat (5)
        begin
            send_req(rand_req());
        end
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        wait_drain();
        repeat (5)
        begin
            send_req(rand_req());
        end
        send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
        wait_drain();
    endtask

    // random phases, mostly short lists, one phase with no idling at all
    task automatic test_random();
        int len;
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:       len = 2;
                3:       len = MAX_ITEMS;
                6:       len = $urandom_range(MAX_ITEMS, 1);
                default: len = $urandom_range(12, 2);
            endcase
            write_length(LEN_W'(len));
            calm_req = (phase == 4);
            calm_rsp = (phase == 4);
            repeat (12)
            begin
                send_req(rand_req());
            end
            // end each phase with a dump so every move gets checked
            send_req(make_req(olme_pkg::OP_DUMP, '0, '0));
            wait_drain();
        end
        calm_req = 1'b0;
        calm_rsp = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        length_reg = olme_pkg::LIST_LENGTH_RESET;
        rebuild_order();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the engine runs its rebuild sweep first; the first request waits
        test_reset_order();
        test_length_extremes();
        test_directed_moves();
        test_backpressure();
        test_drain_pause();
        test_random();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d dumps), %0d dump items checked",
                 requests_sent, dumps_sent, results_seen);
        $display("list length rewritten %0d times, lengths 0, 1, 64, 65, 127 included",
                 length_writes);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("timeout with %0d dump items outstanding", dump_expect.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
